// File: src/flacfh_pkg.sv
// Shared types, constants and table functions of the FLAC frame header parser.
// Used by flacfh_decode, flacfh_parser and flac_frame_header_parser; depends on nothing.
package flacfh_pkg;

    localparam logic [13:0] SYNC_CODE = 14'b11111111111110;

    localparam logic [16:0] BS_192 = 17'd192;
    localparam logic [16:0] BS_576 = 17'd576;
    localparam logic [16:0] BS_256 = 17'd256;

    localparam logic [19:0] RATE_KHZ_SCALE  = 20'd1000;
    localparam logic [19:0] RATE_DECA_SCALE = 20'd10;

    localparam logic [3:0] BSC_RESERVED = 4'd0;
    localparam logic [3:0] BSC_192      = 4'd1;
    localparam logic [3:0] BSC_576      = 4'd2;
    localparam logic [3:0] BSC_4608     = 4'd5;
    localparam logic [3:0] BSC_8BIT     = 4'd6;
    localparam logic [3:0] BSC_16BIT    = 4'd7;
    localparam logic [3:0] BSC_256      = 4'd8;

    localparam logic [3:0] SRC_KHZ     = 4'd12;
    localparam logic [3:0] SRC_HZ      = 4'd13;
    localparam logic [3:0] SRC_DECA    = 4'd14;
    localparam logic [3:0] SRC_INVALID = 4'd15;

    localparam logic [3:0] CHA_LAST_INDEP = 4'd7;
    localparam logic [3:0] CHA_LEFT_SIDE  = 4'd8;
    localparam logic [3:0] CHA_RIGHT_SIDE = 4'd9;
    localparam logic [3:0] CHA_MID_SIDE   = 4'd10;

    localparam logic [2:0] MODE_INDEPENDENT = 3'd0;
    localparam logic [2:0] MODE_LEFT_SIDE   = 3'd1;
    localparam logic [2:0] MODE_RIGHT_SIDE  = 3'd2;
    localparam logic [2:0] MODE_MID_SIDE    = 3'd3;
    localparam logic [2:0] MODE_INVALID     = 3'd4;

    localparam int OUT_DATA_W = 96;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_FIXED    = 7'b0000010,
        PH_NUM_LEAD = 7'b0000100,
        PH_NUM_CONT = 7'b0001000,
        PH_BLOCK    = 7'b0010000,
        PH_RATE     = 7'b0100000,
        PH_CRC      = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic        variable_blocking;
        logic [16:0] block_size;
        logic [19:0] sample_rate;
        logic [3:0]  channel_assignment;
        logic [3:0]  channel_count;
        logic [2:0]  channel_mode;
        logic [4:0]  sample_bits;
        logic [35:0] coded_number;
        logic        sync_ok;
        logic        crc_ok;
        logic        rate_code_invalid;
        logic        number_code_error;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [19:0] rate_table(input logic [3:0] code);
        logic [19:0] r;
        case (code)
            4'd1:    r = 20'd88200;
            4'd2:    r = 20'd176400;
            4'd3:    r = 20'd192000;
            4'd4:    r = 20'd8000;
            4'd5:    r = 20'd16000;
            4'd6:    r = 20'd22050;
            4'd7:    r = 20'd24000;
            4'd8:    r = 20'd32000;
            4'd9:    r = 20'd44100;
            4'd10:   r = 20'd48000;
            4'd11:   r = 20'd96000;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] bits_table(input logic [2:0] code);
        logic [4:0] r;
        case (code)
            3'd1:    r = 5'd8;
            3'd2:    r = 5'd12;
            3'd4:    r = 5'd16;
            3'd5:    r = 5'd20;
            3'd6:    r = 5'd24;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// File: src/flac_frame_header_parser.sv
// Top level: input request register, header parser and result register.
// Depends on flacfh_pkg and instantiates flacfh_parser.
// A header's CRC byte passes the input register, then the result register, to m_tdata.
// One header byte per cycle when not stalled; the parser updates its state once per byte.
// A result that waits on m_tready stalls s_tready only once the next CRC byte is held.
// Reset (aresetn low, synchronous) empties both registers and returns the parser to idle.
module flac_frame_header_parser (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // data_byte
    input  logic [0:0]                         s_tuser,  // frame_start
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // block_size, sample_rate, channel_assignment, channel_count, channel_mode,
    // sample_bits, coded_number, sync_ok, crc_ok, rate_code_invalid,
    // number_code_error, zero fill
    output logic [flacfh_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]                         m_tuser   // variable_blocking
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        res_valid;
    flacfh_pkg::result_t res;
    flacfh_pkg::result_t out_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !res_valid);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    flacfh_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .data_byte   (in_byte_reg),
        .frame_start (in_start_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.variable_blocking;
    assign m_tdata  = {3'd0,
                       out_reg.number_code_error,
                       out_reg.rate_code_invalid,
                       out_reg.crc_ok,
                       out_reg.sync_ok,
                       out_reg.coded_number,
                       out_reg.sample_bits,
                       out_reg.channel_mode,
                       out_reg.channel_count,
                       out_reg.channel_assignment,
                       out_reg.sample_rate,
                       out_reg.block_size};

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && res_valid && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("Input request dropped while the result register was blocked.");

    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("Empty input register refused a request.");

    a_refill_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (in_valid_reg == $past(s_tvalid)))
        else $error("Input register did not refill after the parser took its byte.");

endmodule

// File: src/flacfh_decode.sv
// Turns the collected header words and accumulators into one decoded result.
// Depends on flacfh_pkg for the result type, codes and tables.
module flacfh_decode (
    input  logic [31:0]        fixed_word,
    input  logic [35:0]        number,
    input  logic [15:0]        block_acc,
    input  logic [15:0]        rate_acc,
    input  logic [7:0]         crc,
    input  logic [7:0]         crc_byte,
    input  logic               number_error,
    output flacfh_pkg::result_t res
);

    logic [3:0] bs_code;
    logic [3:0] sr_code;
    logic [3:0] ch_code;

    assign bs_code = fixed_word[15:12];
    assign sr_code = fixed_word[11:8];
    assign ch_code = fixed_word[7:4];

    always_comb begin
        res = '0;
        res.variable_blocking  = fixed_word[16];
        res.channel_assignment = ch_code;
        res.sample_bits        = flacfh_pkg::bits_table(fixed_word[3:1]);
        res.coded_number       = number;
        res.sync_ok            = (fixed_word[31:18] == flacfh_pkg::SYNC_CODE);
        res.crc_ok             = (crc == crc_byte);
        res.rate_code_invalid  = (sr_code == flacfh_pkg::SRC_INVALID);
        res.number_code_error  = number_error;

        if (bs_code == flacfh_pkg::BSC_RESERVED) begin
            res.block_size = 17'd0;
        end else if (bs_code == flacfh_pkg::BSC_192) begin
            res.block_size = flacfh_pkg::BS_192;
        end else if (bs_code inside {[flacfh_pkg::BSC_576:flacfh_pkg::BSC_4608]}) begin
            res.block_size = flacfh_pkg::BS_576 << (bs_code - flacfh_pkg::BSC_576);
        end else if (bs_code == flacfh_pkg::BSC_8BIT || bs_code == flacfh_pkg::BSC_16BIT) begin
            res.block_size = {1'b0, block_acc} + 17'd1;
        end else begin
            res.block_size = flacfh_pkg::BS_256 << (bs_code - flacfh_pkg::BSC_256);
        end

        case (sr_code)
            flacfh_pkg::SRC_KHZ:     res.sample_rate = {12'd0, rate_acc[7:0]}
                                                     * flacfh_pkg::RATE_KHZ_SCALE;
            flacfh_pkg::SRC_HZ:      res.sample_rate = {4'd0, rate_acc};
            flacfh_pkg::SRC_DECA:    res.sample_rate = {4'd0, rate_acc}
                                                     * flacfh_pkg::RATE_DECA_SCALE;
            flacfh_pkg::SRC_INVALID: res.sample_rate = 20'd0;
            default:                 res.sample_rate = flacfh_pkg::rate_table(sr_code);
        endcase

        if (ch_code <= flacfh_pkg::CHA_LAST_INDEP) begin
            res.channel_count = ch_code + 4'd1;
            res.channel_mode  = flacfh_pkg::MODE_INDEPENDENT;
        end else if (ch_code == flacfh_pkg::CHA_LEFT_SIDE) begin
            res.channel_count = 4'd2;
            res.channel_mode  = flacfh_pkg::MODE_LEFT_SIDE;
        end else if (ch_code == flacfh_pkg::CHA_RIGHT_SIDE) begin
            res.channel_count = 4'd2;
            res.channel_mode  = flacfh_pkg::MODE_RIGHT_SIDE;
        end else if (ch_code == flacfh_pkg::CHA_MID_SIDE) begin
            res.channel_count = 4'd2;
            res.channel_mode  = flacfh_pkg::MODE_MID_SIDE;
        end else begin
            res.channel_count = 4'd0;
            res.channel_mode  = flacfh_pkg::MODE_INVALID;
        end
    end

endmodule

// File: src/flacfh_parser.sv
// Header parse state machine: phase, field accumulators and running CRC-8.
// Depends on flacfh_pkg and instantiates flacfh_decode for the result fields.
module flacfh_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          data_byte,
    input  logic                frame_start,
    output logic                res_valid,
    output flacfh_pkg::result_t res
);

    flacfh_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [31:0] fixed_reg, fixed_next, cur_fixed;
    logic [35:0] num_reg, num_next, cur_num;
    logic [2:0]  cont_reg, cont_next, cur_cont;
    logic [15:0] bs_reg, bs_next, cur_bs;
    logic [15:0] rate_reg, rate_next, cur_rate;
    logic [7:0]  crc_reg, crc_next, cur_crc;
    logic [1:0]  cnt_reg, cnt_next, cur_cnt;
    logic        nerr_reg, nerr_next, cur_nerr;

    flacfh_pkg::phase_t rate_phase, after_num_phase;
    logic [1:0]  rate_cnt, after_num_cnt;
    logic [2:0]  lead_n;
    logic [7:0]  lead_mask;
    logic        lead_err;
    logic [3:0]  sr_code;
    logic [3:0]  bs_code;

    assign sr_code = cur_fixed[11:8];
    assign bs_code = cur_fixed[15:12];

    always_comb begin
        if (frame_start) begin
            cur_phase = flacfh_pkg::PH_FIXED;
            cur_fixed = '0;
            cur_num   = '0;
            cur_cont  = '0;
            cur_bs    = '0;
            cur_rate  = '0;
            cur_crc   = '0;
            cur_cnt   = '0;
            cur_nerr  = 1'b0;
        end else begin
            cur_phase = phase_reg;
            cur_fixed = fixed_reg;
            cur_num   = num_reg;
            cur_cont  = cont_reg;
            cur_bs    = bs_reg;
            cur_rate  = rate_reg;
            cur_crc   = crc_reg;
            cur_cnt   = cnt_reg;
            cur_nerr  = nerr_reg;
        end
    end

    always_comb begin
        if (sr_code == flacfh_pkg::SRC_KHZ) begin
            rate_phase = flacfh_pkg::PH_RATE;
            rate_cnt   = 2'd1;
        end else if (sr_code == flacfh_pkg::SRC_HZ || sr_code == flacfh_pkg::SRC_DECA) begin
            rate_phase = flacfh_pkg::PH_RATE;
            rate_cnt   = 2'd2;
        end else begin
            rate_phase = flacfh_pkg::PH_CRC;
            rate_cnt   = cur_cnt;
        end
        if (bs_code == flacfh_pkg::BSC_8BIT) begin
            after_num_phase = flacfh_pkg::PH_BLOCK;
            after_num_cnt   = 2'd1;
        end else if (bs_code == flacfh_pkg::BSC_16BIT) begin
            after_num_phase = flacfh_pkg::PH_BLOCK;
            after_num_cnt   = 2'd2;
        end else begin
            after_num_phase = rate_phase;
            after_num_cnt   = rate_cnt;
        end
    end

    always_comb begin
        lead_err = 1'b0;
        if (!data_byte[7]) begin
            lead_n = 3'd0; lead_mask = 8'h7F;
        end else if (data_byte[7:5] == 3'b110) begin
            lead_n = 3'd1; lead_mask = 8'h1F;
        end else if (data_byte[7:4] == 4'b1110) begin
            lead_n = 3'd2; lead_mask = 8'h0F;
        end else if (data_byte[7:3] == 5'b11110) begin
            lead_n = 3'd3; lead_mask = 8'h07;
        end else if (data_byte[7:2] == 6'b111110) begin
            lead_n = 3'd4; lead_mask = 8'h03;
        end else if (data_byte[7:1] == 7'b1111110) begin
            lead_n = 3'd5; lead_mask = 8'h01;
        end else if (data_byte == 8'hFE) begin
            // A seven-byte number only fits a sample number.
            lead_n = 3'd6; lead_mask = 8'h00;
            lead_err = !cur_fixed[16];
        end else begin
            lead_n = 3'd0; lead_mask = 8'h00;
            lead_err = 1'b1;
        end
    end

    always_comb begin
        phase_next = cur_phase;
        fixed_next = cur_fixed;
        num_next   = cur_num;
        cont_next  = cur_cont;
        bs_next    = cur_bs;
        rate_next  = cur_rate;
        crc_next   = cur_crc;
        cnt_next   = cur_cnt;
        nerr_next  = cur_nerr;
        res_valid  = 1'b0;
        case (cur_phase)
            flacfh_pkg::PH_IDLE: begin
            end
            flacfh_pkg::PH_CRC: begin
                res_valid  = 1'b1;
                phase_next = flacfh_pkg::PH_IDLE;
            end
            flacfh_pkg::PH_FIXED: begin
                crc_next   = flacfh_pkg::crc8_byte(cur_crc, data_byte);
                fixed_next = {cur_fixed[23:0], data_byte};
                if (cur_cnt == 2'd3) begin
                    cnt_next   = 2'd0;
                    phase_next = flacfh_pkg::PH_NUM_LEAD;
                end else begin
                    cnt_next = cur_cnt + 2'd1;
                end
            end
            flacfh_pkg::PH_NUM_LEAD: begin
                crc_next  = flacfh_pkg::crc8_byte(cur_crc, data_byte);
                nerr_next = cur_nerr | lead_err;
                num_next  = {28'd0, data_byte & lead_mask};
                cont_next = lead_n;
                if (lead_n == 3'd0) begin
                    phase_next = after_num_phase;
                    cnt_next   = after_num_cnt;
                end else begin
                    phase_next = flacfh_pkg::PH_NUM_CONT;
                end
            end
            flacfh_pkg::PH_NUM_CONT: begin
                crc_next  = flacfh_pkg::crc8_byte(cur_crc, data_byte);
                nerr_next = cur_nerr | (data_byte[7:6] != 2'b10);
                num_next  = {cur_num[29:0], data_byte[5:0]};
                cont_next = cur_cont - 3'd1;
                if (cont_next == 3'd0) begin
                    phase_next = after_num_phase;
                    cnt_next   = after_num_cnt;
                end
            end
            flacfh_pkg::PH_BLOCK: begin
                crc_next = flacfh_pkg::crc8_byte(cur_crc, data_byte);
                bs_next  = {cur_bs[7:0], data_byte};
                cnt_next = cur_cnt - 2'd1;
                if (cnt_next == 2'd0) begin
                    phase_next = rate_phase;
                    if (rate_phase == flacfh_pkg::PH_RATE) begin
                        cnt_next = rate_cnt;
                    end
                end
            end
            flacfh_pkg::PH_RATE: begin
                crc_next  = flacfh_pkg::crc8_byte(cur_crc, data_byte);
                rate_next = {cur_rate[7:0], data_byte};
                cnt_next  = cur_cnt - 2'd1;
                if (cnt_next == 2'd0) begin
                    phase_next = flacfh_pkg::PH_CRC;
                end
            end
            default: begin
                phase_next = flacfh_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= flacfh_pkg::PH_IDLE;
            fixed_reg <= '0;
            num_reg   <= '0;
            cont_reg  <= '0;
            bs_reg    <= '0;
            rate_reg  <= '0;
            crc_reg   <= '0;
            cnt_reg   <= '0;
            nerr_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            fixed_reg <= fixed_next;
            num_reg   <= num_next;
            cont_reg  <= cont_next;
            bs_reg    <= bs_next;
            rate_reg  <= rate_next;
            crc_reg   <= crc_next;
            cnt_reg   <= cnt_next;
            nerr_reg  <= nerr_next;
        end
    end

    flacfh_decode u_decode (
        .fixed_word   (cur_fixed),
        .number       (cur_num),
        .block_acc    (cur_bs),
        .rate_acc     (cur_rate),
        .crc          (cur_crc),
        .crc_byte     (data_byte),
        .number_error (cur_nerr),
        .res          (res)
    );

endmodule
